### rtl/slma_pkg.sv
package slma_pkg;

    // Width of one distance value in cm
    localparam int VAL_W = 9;

    // Default length of the averaging window
    localparam int WINDOW_DEF = 10;

    // Register port
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register word index, taken from paddr[ADDR_W-1:2]
    typedef enum logic [ADDR_W-3:0] {
        REG_CHANGE_LIMIT = 1'b0
    } reg_idx_t;

    localparam logic [VAL_W-1:0] CHANGE_LIMIT_RST = 9'd30;

endpackage

### rtl/slew_limited_moving_average_core.sv
// Slew-limited moving average of ultrasonic distance samples.
// Input channel: distance_cm with input_valid / input_stall; a beat moves at a
// rising edge with valid high and stall low. A zero sample repeats the last
// accepted value; any other sample is clamped to within change_limit of it.
// Output channel: accepted_cm and average_cm with result_valid / result_stall,
// one result beat per input beat, in order.
// A beat passes the input register, the state update and then the divide into
// the output register, which raises result_valid.
// Throughput: one beat per cycle while result_stall is low; the window ring,
// running sum and slot pointer are updated once per beat, and the divide by
// WINDOW is a single constant multiply in its own stage.
// When the receiver stalls, the output register holds its beat and the
// stages behind it keep filling; input_stall rises once every stage is full.
// Register port: change_limit at byte address 0 (APB, pready always high).
// Reset clears the pipeline and the running sum, but not the ring (read as zero
// until written), and sets change_limit to 30, so the average ramps up from zero.
module slew_limited_moving_average_core #(
    parameter int WINDOW = slma_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slma_pkg::ADDR_W-1:0]       paddr,
    input  logic [slma_pkg::DATA_W-1:0]       pwdata,
    output logic [slma_pkg::DATA_W-1:0]       prdata,
    output logic                              pready,
    // Input channel
    input  logic                              input_valid,
    output logic                              input_stall,
    input  logic [slma_pkg::VAL_W-1:0]        distance_cm,
    // Result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic [slma_pkg::VAL_W-1:0]        accepted_cm,
    output logic [slma_pkg::VAL_W-1:0]        average_cm
);

    localparam int VAL_W     = slma_pkg::VAL_W;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int SUM_W     = $clog2(((1 << VAL_W) - 1) * WINDOW + 1);
    // floor(x / WINDOW) == (x * DIV_MULT) >> DIV_SHIFT for all x below 2**SUM_W
    localparam int DIV_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int unsigned DIV_MULT = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
    localparam int MULT_W    = SUM_W + 1;
    localparam int PROD_W    = SUM_W + MULT_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

    // Configuration
    logic [VAL_W-1:0]  change_limit_reg;
    logic              cfg_wr;

    // Pipeline control
    logic              s1_vld_reg;
    logic              s2_vld_reg;
    logic              out_vld_reg;
    logic              en1;
    logic              en2;
    logic              en3;
    logic              proc;
    logic              move3;

    // Stage 1: input register
    logic [VAL_W-1:0]  s1_dist_reg;

    // Window state
    logic [VAL_W-1:0]  last_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [SLOT_W-1:0] slot_next;
    logic              last_slot;
    logic              wrap_reg;
    logic              rd_vld_reg;
    logic [VAL_W-1:0]  mem_rd_reg;
    logic [VAL_W-1:0]  oldest;
    logic [VAL_W-1:0]  ring [WINDOW];

    // Clamp
    logic [VAL_W-1:0]  acc;
    logic [VAL_W-1:0]  diff_up;
    logic [VAL_W-1:0]  diff_dn;

    // Stage 2 and divide
    logic [VAL_W-1:0]  s2_acc_reg;
    logic [PROD_W-1:0] prod;

    // Output register
    logic [VAL_W-1:0]  accepted_reg;
    logic [VAL_W-1:0]  average_reg;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[slma_pkg::ADDR_W-1:2] == slma_pkg::REG_CHANGE_LIMIT);

    always_comb
    begin
        prdata = '0;
        if (paddr[slma_pkg::ADDR_W-1:2] == slma_pkg::REG_CHANGE_LIMIT)
        begin
            prdata = slma_pkg::DATA_W'(change_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            change_limit_reg <= slma_pkg::CHANGE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            change_limit_reg <= pwdata[VAL_W-1:0];
        end
    end

    // Advance each stage when the one ahead is empty or moving
    assign en3         = !out_vld_reg || !result_stall;
    assign en2         = !s2_vld_reg || en3;
    assign en1         = !s1_vld_reg || en2;
    assign proc        = s1_vld_reg && en2;
    assign move3       = s2_vld_reg && en3;
    assign input_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_vld_reg <= input_valid;
            end
            if (en2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (en3)
            begin
                out_vld_reg <= s2_vld_reg;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (en1 && input_valid)
        begin
            s1_dist_reg <= distance_cm;
        end
    end

    // Hold on dropout, else clamp the step to the change limit
    assign diff_up = s1_dist_reg - last_reg;
    assign diff_dn = last_reg - s1_dist_reg;

    always_comb
    begin
        acc = s1_dist_reg;
        if (s1_dist_reg == '0)
        begin
            acc = last_reg;
        end
        else if (s1_dist_reg > last_reg)
        begin
            if (diff_up > change_limit_reg)
            begin
                acc = last_reg + change_limit_reg;
            end
        end
        else if (diff_dn > change_limit_reg)
        begin
            acc = last_reg - change_limit_reg;
        end
    end

    // Drop the oldest entry from the sum and add the new one
    assign oldest    = rd_vld_reg ? mem_rd_reg : '0;
    assign sum_next  = sum_reg - SUM_W'(oldest) + SUM_W'(acc);
    assign last_slot = (slot_reg == LAST_SLOT);
    assign slot_next = last_slot ? '0 : slot_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg   <= '0;
            sum_reg    <= '0;
            slot_reg   <= '0;
            wrap_reg   <= 1'b0;
            rd_vld_reg <= 1'b0;
        end
        else if (proc)
        begin
            last_reg   <= acc;
            sum_reg    <= sum_next;
            slot_reg   <= slot_next;
            rd_vld_reg <= wrap_reg || last_slot;
            if (last_slot)
            begin
                wrap_reg <= 1'b1;
            end
        end
    end

    // Write the new entry and prefetch the next oldest one
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            ring[slot_reg] <= acc;
            mem_rd_reg     <= ring[slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            s2_acc_reg <= acc;
        end
    end

    // Divide the sum by WINDOW through a reciprocal multiply
    assign prod = PROD_W'(sum_reg) * PROD_W'(DIV_MULT);

    always_ff @(posedge clk)
    begin
        if (move3)
        begin
            accepted_reg <= s2_acc_reg;
            average_reg  <= VAL_W'(prod >> DIV_SHIFT);
        end
    end

    assign result_valid = out_vld_reg;
    assign accepted_cm  = accepted_reg;
    assign average_cm   = average_reg;

    // The running sum always matches the last update
    a_sum_update: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (sum_reg == $past(sum_next)) && (last_reg == s2_acc_reg))
        else $error("running sum or last value not updated with the beat");

    // State moves only with a beat
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc |=> $stable(sum_reg) && $stable(slot_reg) && $stable(last_reg))
        else $error("window state changed without a beat");

    // Slot pointer stays within the window
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= LAST_SLOT)
        else $error("slot pointer beyond window");

    // Once wrapped, every prefetched entry is a written one
    a_wrap_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (wrap_reg && proc) |=> (wrap_reg && rd_vld_reg))
        else $error("ring wrap state lost");

    // Stage 1 is never overwritten while full and held
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (input_valid && !input_stall) |-> (!s1_vld_reg || en2))
        else $error("input beat taken into a held stage");

endmodule
